/* rtl/core/dcsl_pkg.sv */
// ----------------------------------------------------------------------------
// dcsl_pkg
// Shared types and constants for the drive command slew limiter.
// ----------------------------------------------------------------------------
package dcsl_pkg;

    // Request opcodes
    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_JOYSTICK = 2'd1,
        OP_SETPOINT = 2'd2,
        OP_ENABLE   = 2'd3
    } t_opcode;

    // Configuration register indexes
    localparam logic [2:0] CFG_WHEELBASE = 3'd0;
    localparam logic [2:0] CFG_SPEED_SLEW = 3'd1;
    localparam logic [2:0] CFG_TURN_SLEW = 3'd2;
    localparam logic [2:0] CFG_DEBOUNCE = 3'd3;
    localparam logic [2:0] CFG_HOLD = 3'd4;
    localparam logic [2:0] CFG_TIMEOUT = 3'd5;
    localparam logic [2:0] CFG_FALLBACK = 3'd6;

    localparam int CFG_W = 20;
    localparam int DIV_W = 36;     // dividend width of the divide-by-1000 unit
    localparam int CRD_W = 46;     // CORDIC x/y datapath
    localparam int ANG_W = 22;     // angle accumulator, microradians, signed
    localparam int CRD_STEPS = 21;

    localparam logic [10:0] ANGLE_MAX = 11'd1571;

    // atan(2^-i) in microradians, rounded
    function automatic logic [19:0] atan_urad(input logic [4:0] i);
        logic [19:0] v;
        unique case (i)
            5'd0:  v = 20'd785398;
            5'd1:  v = 20'd463648;
            5'd2:  v = 20'd244979;
            5'd3:  v = 20'd124355;
            5'd4:  v = 20'd62419;
            5'd5:  v = 20'd31240;
            5'd6:  v = 20'd15624;
            5'd7:  v = 20'd7812;
            5'd8:  v = 20'd3906;
            5'd9:  v = 20'd1953;
            5'd10: v = 20'd977;
            5'd11: v = 20'd488;
            5'd12: v = 20'd244;
            5'd13: v = 20'd122;
            5'd14: v = 20'd61;
            5'd15: v = 20'd31;
            5'd16: v = 20'd15;
            5'd17: v = 20'd8;
            5'd18: v = 20'd4;
            5'd19: v = 20'd2;
            5'd20: v = 20'd1;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/core/dcsl_cmd_if.sv */
// ----------------------------------------------------------------------------
// dcsl_cmd_if
// Request channel: opcode, timestamp and event payload.
// ----------------------------------------------------------------------------
interface dcsl_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [31:0]        now_ms;
    logic               start_button;
    logic               deadman_button;
    logic signed [15:0] target_speed;
    logic signed [15:0] curvature;
    logic               enable_value;

    modport source (output valid, opcode, now_ms, start_button, deadman_button,
                    target_speed, curvature, enable_value, input ready);
    modport sink (input valid, opcode, now_ms, start_button, deadman_button,
                  target_speed, curvature, enable_value, output ready);
endinterface

/* rtl/core/dcsl_res_if.sv */
// ----------------------------------------------------------------------------
// dcsl_res_if
// Result channel: limited speed and steering angle.
// ----------------------------------------------------------------------------
interface dcsl_res_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] speed;
    logic signed [11:0] steer_mrad;

    modport source (output valid, speed, steer_mrad, input ready);
    modport sink (input valid, speed, steer_mrad, output ready);
endinterface

/* rtl/core/dcsl_div1000.sv */
// ----------------------------------------------------------------------------
// dcsl_div1000
// Divide by 1000 by reciprocal multiplication, one 17-bit half of the reciprocal at a time.
// ----------------------------------------------------------------------------
module dcsl_div1000
    import dcsl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quot
);

    // x / 1000 = (x >> 3) / 125; 1/125 is ceil(2^40 / 125), exact for x >> 3 < 2^33.
    // The 34-bit reciprocal is applied in two 17-bit halves on one multiplier.
    localparam int          SH_W  = DIV_W - 3;
    localparam int          ACC_W = 67;
    localparam logic [33:0] RECIP = 34'd8796093023;

    logic             r_busy;
    logic             r_done;
    logic             r_phase;
    logic [SH_W-1:0]  r_x;
    logic [ACC_W-1:0] r_acc;
    logic [16:0]      recip_part;
    logic [49:0]      prod;

    assign recip_part = r_phase ? RECIP[33:17] : RECIP[16:0];
    assign prod       = r_x * recip_part;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
                r_x     <= i_dividend[DIV_W-1:3];
            end else if (r_busy) begin
                if (!r_phase) begin
                    r_acc   <= ACC_W'(prod);
                    r_phase <= 1'b1;
                end else begin
                    r_acc  <= r_acc + (ACC_W'(prod) << 17);
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = DIV_W'(r_acc[ACC_W-1:40]);

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("divider restarted while busy");
    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("divider done while busy");
    a_done_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_phase) else $error("divider done before second product");

endmodule

/* rtl/core/dcsl_cordic.sv */
// ----------------------------------------------------------------------------
// dcsl_cordic
// Normalizes N/D one bit per cycle, then runs 21 vectoring steps for atan.
// ----------------------------------------------------------------------------
module dcsl_cordic
    import dcsl_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [33:0]             i_num,
    input  logic [24:0]             i_den,
    output logic                    o_done,
    output logic signed [ANG_W-1:0] o_angle
);

    typedef enum logic [1:0] {S_IDLE, S_NORM, S_ITER} t_state;

    localparam logic [41:0] NORM_LIM = 42'h100_0000_0000;   // 2^40

    t_state                  r_state;
    logic                    r_done;
    logic [41:0]             r_n;
    logic [41:0]             r_d;
    logic signed [CRD_W-1:0] r_x;
    logic signed [CRD_W-1:0] r_y;
    logic signed [ANG_W-1:0] r_z;
    logic [4:0]              r_i;
    logic signed [CRD_W-1:0] x_sh;
    logic signed [CRD_W-1:0] y_sh;
    logic signed [ANG_W-1:0] step_ang;

    assign x_sh     = r_x >>> r_i;
    assign y_sh     = r_y >>> r_i;
    assign step_ang = ANG_W'(atan_urad(r_i));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_n     <= 42'(i_num);
                        r_d     <= 42'(i_den);
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (r_n < NORM_LIM && r_d < NORM_LIM) begin
                        r_n <= r_n << 1;
                        r_d <= r_d << 1;
                    end else begin
                        r_x     <= CRD_W'(r_d);
                        r_y     <= CRD_W'(r_n);
                        r_z     <= '0;
                        r_i     <= '0;
                        r_state <= S_ITER;
                    end
                end
                S_ITER: begin
                    if (!r_y[CRD_W-1]) begin
                        r_x <= r_x + y_sh;
                        r_y <= r_y - x_sh;
                        r_z <= r_z + step_ang;
                    end else begin
                        r_x <= r_x - y_sh;
                        r_y <= r_y + x_sh;
                        r_z <= r_z - step_ang;
                    end
                    r_i <= r_i + 5'd1;
                    if (r_i == 5'(CRD_STEPS - 1)) begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_z;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == S_IDLE) else $error("cordic started while busy");
    a_x_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ITER |-> !r_x[CRD_W-1]) else $error("cordic x went negative");
    a_done_from_iter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state == S_ITER)) else $error("stray cordic done");

endmodule

/* rtl/core/drive_command_slew_limiter.sv */
// ----------------------------------------------------------------------------
// drive_command_slew_limiter
// Slew-rate limiter for a speed and steering drive command.
// ----------------------------------------------------------------------------
// Requests are timestamped events chosen by opcode. Joystick samples, setpoints
// and enable writes update state from the idle state. A tick runs the
// sequencer: the speed and turn slew steps (slew * dt / 1000) each go through
// the shared divide-by-1000 unit (reciprocal multiply), then the steering angle
// atan(wheelbase * rate / (1000 * speed)) goes through a CORDIC unit (up to 31
// normalizing shifts plus 21 steps) and the same divider again to round to
// milliradians. An angle that is trivially zero or +-1571 skips the CORDIC
// unit and the final divide. A tick that does not emit leaves the sequencer idle.
// Ready is low while a tick is in flight. The result sits in an output
// register until taken; a finished tick waits there only if the previous
// result has not yet been taken. No result is made when the drive is
// disabled or the deadman is not engaged; the motion state is zeroed instead.
// ----------------------------------------------------------------------------
module drive_command_slew_limiter
    import dcsl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    dcsl_cmd_if.sink          i_cmd,
    dcsl_res_if.source        o_res,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_SMUL, S_SDIV, S_TMUL, S_TDIV, S_CLAMP,
        S_ANG, S_CORD, S_ZDIV, S_ZWAIT, S_OUT
    } t_state;

    // configuration
    logic [10:0] r_wheelbase;
    logic [15:0] r_speed_slew;
    logic [19:0] r_turn_slew;
    logic [15:0] r_debounce;
    logic [15:0] r_hold;
    logic [15:0] r_timeout;
    logic [15:0] r_fallback;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheelbase  <= 11'd200;
            r_speed_slew <= 16'd800;
            r_turn_slew  <= 20'd10000;
            r_debounce   <= 16'd400;
            r_hold       <= 16'd1000;
            r_timeout    <= 16'd1000;
            r_fallback   <= 16'd50;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WHEELBASE:  r_wheelbase  <= i_cfg_data[10:0];
                CFG_SPEED_SLEW: r_speed_slew <= i_cfg_data[15:0];
                CFG_TURN_SLEW:  r_turn_slew  <= i_cfg_data;
                CFG_DEBOUNCE:   r_debounce   <= i_cfg_data[15:0];
                CFG_HOLD:       r_hold       <= i_cfg_data[15:0];
                CFG_TIMEOUT:    r_timeout    <= i_cfg_data[15:0];
                CFG_FALLBACK:   r_fallback   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // state
    t_state             r_state;
    logic signed [15:0] r_cur_speed;
    logic signed [23:0] r_cur_rate;
    logic signed [15:0] r_des_speed;
    logic signed [23:0] r_des_rate;
    logic               r_enabled;
    logic               r_engaged;
    logic               r_held;
    logic [31:0]        r_press_time;
    logic [31:0]        r_toggle_time;
    logic [31:0]        r_tick_time;
    logic [15:0]        r_dt;
    logic [22:0]        r_sstep;
    logic [26:0]        r_tstep;
    logic               r_neg;
    logic [10:0]        r_mag;
    logic               r_out_valid;
    logic signed [15:0] r_out_speed;
    logic signed [11:0] r_out_angle;

    logic        accept;
    t_opcode     op;
    logic [31:0] dt_raw;
    logic        timed_out;
    logic [31:0] since_toggle;
    logic [31:0] since_press;
    logic signed [31:0] sp_prod;

    assign accept       = i_cmd.valid && i_cmd.ready;
    assign op           = t_opcode'(i_cmd.opcode);
    assign dt_raw       = i_cmd.now_ms - r_tick_time;
    assign timed_out    = dt_raw > {16'd0, r_timeout};
    assign since_toggle = i_cmd.now_ms - r_toggle_time;
    assign since_press  = i_cmd.now_ms - r_press_time;
    assign sp_prod      = i_cmd.target_speed * i_cmd.curvature;

    // shared divide-by-1000
    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic             div_done;
    logic [DIV_W-1:0] div_quot;
    logic signed [ANG_W-1:0] r_z_angle;
    logic [ANG_W-1:0] z_clip;

    assign z_clip = r_z_angle[ANG_W-1] ? '0 : r_z_angle;

    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        unique case (r_state)
            S_SMUL: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(r_speed_slew * r_dt);
            end
            S_TMUL: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(r_turn_slew * r_dt);
            end
            S_ZDIV: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(z_clip) + DIV_W'(500);
            end
            default: ;
        endcase
    end

    dcsl_div1000 u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // steering angle unit
    logic [23:0]             abs_rate;
    logic [15:0]             abs_speed;
    logic                    crd_start;
    logic                    crd_done;
    logic signed [ANG_W-1:0] crd_angle;

    assign abs_rate  = r_cur_rate[23] ? 24'(-r_cur_rate) : r_cur_rate;
    assign abs_speed = r_cur_speed[15] ? 16'(-r_cur_speed) : r_cur_speed;
    assign crd_start = (r_state == S_ANG) && (r_cur_rate != '0) && (r_wheelbase != '0)
                       && (r_cur_speed != '0);

    dcsl_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (crd_start),
        .i_num   (34'(r_wheelbase * abs_rate)),
        .i_den   (25'(abs_speed) * 25'd1000),
        .o_done  (crd_done),
        .o_angle (crd_angle)
    );

    // slew clamps; the window always contains a value between current and target
    logic signed [24:0] s_lo, s_hi, s_new;
    logic signed [28:0] t_lo, t_hi, t_new;

    always_comb begin
        s_lo  = 25'(r_cur_speed) - 25'(signed'({1'b0, r_sstep}));
        s_hi  = 25'(r_cur_speed) + 25'(signed'({1'b0, r_sstep}));
        s_new = 25'(r_des_speed);
        if (s_new < s_lo) s_new = s_lo;
        else if (s_new > s_hi) s_new = s_hi;
        t_lo  = 29'(r_cur_rate) - 29'(signed'({1'b0, r_tstep}));
        t_hi  = 29'(r_cur_rate) + 29'(signed'({1'b0, r_tstep}));
        t_new = 29'(r_des_rate);
        if (t_new < t_lo) t_new = t_lo;
        else if (t_new > t_hi) t_new = t_hi;
    end

    assign i_cmd.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cur_speed   <= '0;
            r_cur_rate    <= '0;
            r_des_speed   <= '0;
            r_des_rate    <= '0;
            r_enabled     <= 1'b1;
            r_engaged     <= 1'b0;
            r_held        <= 1'b0;
            r_press_time  <= '0;
            r_toggle_time <= '0;
            r_tick_time   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            // the output step reloads the register itself whenever it is taken
            if (o_res.ready && r_state != S_OUT) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (op)
                            OP_JOYSTICK: begin
                                if (i_cmd.start_button && since_toggle > 32'(r_debounce)) begin
                                    r_enabled     <= !r_enabled;
                                    r_toggle_time <= i_cmd.now_ms;
                                end
                                if (i_cmd.deadman_button) begin
                                    if (!r_held) begin
                                        r_held       <= 1'b1;
                                        r_press_time <= i_cmd.now_ms;
                                    end else if (since_press > 32'(r_hold)) begin
                                        r_engaged <= 1'b1;
                                    end
                                end else begin
                                    r_held    <= 1'b0;
                                    r_engaged <= 1'b0;
                                end
                            end
                            OP_SETPOINT: begin
                                r_des_speed <= i_cmd.target_speed;
                                r_des_rate  <= 24'(sp_prod >>> 10);
                            end
                            OP_ENABLE: r_enabled <= i_cmd.enable_value;
                            OP_TICK: begin
                                r_tick_time <= i_cmd.now_ms;
                                r_dt        <= timed_out ? r_fallback : dt_raw[15:0];
                                if (timed_out || !(r_enabled && r_engaged)) begin
                                    r_cur_speed <= '0;
                                    r_cur_rate  <= '0;
                                end
                                if (r_enabled && r_engaged) r_state <= S_SMUL;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SMUL: r_state <= S_SDIV;
                S_SDIV: begin
                    if (div_done) begin
                        r_sstep <= div_quot[22:0];
                        r_state <= S_TMUL;
                    end
                end
                S_TMUL: r_state <= S_TDIV;
                S_TDIV: begin
                    if (div_done) begin
                        r_tstep <= div_quot[26:0];
                        r_state <= S_CLAMP;
                    end
                end
                S_CLAMP: begin
                    r_cur_speed <= 16'(s_new);
                    r_cur_rate  <= 24'(t_new);
                    r_state     <= S_ANG;
                end
                S_ANG: begin
                    if (r_cur_rate == '0 || r_wheelbase == '0) begin
                        r_neg   <= 1'b0;
                        r_mag   <= '0;
                        r_state <= S_OUT;
                    end else if (r_cur_speed == '0) begin
                        r_neg   <= r_cur_rate[23];
                        r_mag   <= ANGLE_MAX;
                        r_state <= S_OUT;
                    end else begin
                        // sign of the angle: rate sign times speed sign
                        r_neg   <= r_cur_rate[23] != r_cur_speed[15];
                        r_state <= S_CORD;
                    end
                end
                S_CORD: begin
                    if (crd_done) begin
                        r_z_angle <= crd_angle;
                        r_state   <= S_ZDIV;
                    end
                end
                S_ZDIV: r_state <= S_ZWAIT;
                S_ZWAIT: begin
                    if (div_done) begin
                        r_mag   <= (div_quot > DIV_W'(ANGLE_MAX)) ? ANGLE_MAX : div_quot[10:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_speed <= r_cur_speed;
                        r_out_angle <= r_neg ? 12'(-$signed({1'b0, r_mag}))
                                             : 12'($signed({1'b0, r_mag}));
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.speed      = r_out_speed;
    assign o_res.steer_mrad = r_out_angle;

    a_rise_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result raised outside the output step");
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_angle <= 12'sd1571 && r_out_angle >= -12'sd1571))
        else $error("steering angle out of range");
    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && op == OP_TICK && !(r_enabled && r_engaged)) |=>
        (r_state == S_IDLE && r_cur_speed == '0 && r_cur_rate == '0))
        else $error("inactive tick did not zero motion state");

endmodule

/* tb/dcsl_tb_cmd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcsl_tb_cmd_if
// Testbench copy of nothing: the block's interfaces come from the RTL files.
// ----------------------------------------------------------------------------
// The request and result interfaces are compiled from the RTL sources
// (dcsl_cmd_if, dcsl_res_if); this file holds the testbench-side types only.
package dcsl_tb_types;
    import dcsl_pkg::*;

    typedef struct {
        t_opcode            op;
        logic [31:0]        now_ms;
        logic               start_button;
        logic               deadman_button;
        logic signed [15:0] target_speed;
        logic signed [15:0] curvature;
        logic               enable_value;
    } t_request;

    typedef struct {
        logic signed [15:0] speed;
        logic signed [11:0] steer_mrad;
    } t_command;
endpackage

/* tb/drive_command_slew_limiter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drive_command_slew_limiter_tb
// Self-checking bench for the drive command slew limiter.
// ----------------------------------------------------------------------------
// A queue of requests feeds a clocked driver; a clocked monitor compares each
// result taken with the oldest expected drive command, which an in-bench
// predictor works out from its own copy of the state and the registers.
// Phases: reset values, extreme registers, random registers; idling pattern
// swaps between phases; one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module drive_command_slew_limiter_tb;
    import dcsl_pkg::*;
    import dcsl_tb_types::*;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [2:0] i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;

    dcsl_cmd_if cmd ();
    dcsl_res_if res ();

    drive_command_slew_limiter uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_res(res),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // ---------------- predictor state ----------------
    logic [10:0] wheelbase;
    logic [15:0] speed_slew_r;
    logic [19:0] turn_slew_r;
    logic [15:0] debounce_ms, hold_ms, timeout_ms, fallback_ms;
    longint cur_speed, cur_rate, want_speed, want_rate;
    bit drive_on, dm_engaged, dm_held;
    logic [31:0] dm_press_t, toggle_t, tick_t;

    t_request pending_requests[$];
    t_command expected_commands[$];
    int errors;
    int send_idle_pct, recv_idle_pct;
    int hold_off_cycles;
    bit sender_pause;

    localparam longint ATAN_URAD [21] = '{785398, 463648, 244979, 124355, 62419,
        31240, 15624, 7812, 3906, 1953, 977, 488, 244, 122, 61, 31, 15, 8, 4, 2, 1};

    function automatic longint fshift(longint v, int s);
        return v >>> s;   // arithmetic shift floors
    endfunction

    function automatic longint angle_mrad(longint n, longint d);
        longint x, y, z, nx, ny;
        z = 0;
        while (n < (64'sd1 <<< 40) && d < (64'sd1 <<< 40)) begin
            n = n <<< 1;
            d = d <<< 1;
        end
        x = d;
        y = n;
        for (int i = 0; i < 21; i++) begin
            if (y >= 0) begin
                nx = x + fshift(y, i); ny = y - fshift(x, i); z += ATAN_URAD[i];
            end else begin
                nx = x - fshift(y, i); ny = y + fshift(x, i); z -= ATAN_URAD[i];
            end
            x = nx;
            y = ny;
        end
        if (z < 0) z = 0;
        z = (z + 500) / 1000;
        return (z > 1571) ? 1571 : z;
    endfunction

    function automatic longint steer_angle(longint spd, longint rate);
        longint m;
        if (rate == 0 || wheelbase == 0) return 0;
        if (spd == 0) return (rate > 0) ? 1571 : -1571;
        m = angle_mrad(longint'(wheelbase) * (rate < 0 ? -rate : rate),
                       1000 * (spd < 0 ? -spd : spd));
        return ((rate < 0) != (spd < 0)) ? -m : m;
    endfunction

    function automatic longint clip(longint lo, longint hi, longint v);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    task automatic predict_command(input t_request r);
        longint dt, ss, ts, p;
        t_command c;
        case (r.op)
            OP_JOYSTICK: begin
                if (r.start_button && (r.now_ms - toggle_t) > debounce_ms) begin
                    drive_on = !drive_on;
                    toggle_t = r.now_ms;
                end
                if (r.deadman_button) begin
                    if (!dm_held) begin
                        dm_press_t = r.now_ms;
                        dm_held = 1;
                    end
                    if (32'(r.now_ms - dm_press_t) > hold_ms) dm_engaged = 1;
                end else begin
                    dm_held = 0;
                    dm_engaged = 0;
                end
            end
            OP_SETPOINT: begin
                p = longint'(r.target_speed) * longint'(r.curvature);
                want_speed = r.target_speed;
                want_rate = clip(-8388608, 8388607, p >>> 10);
            end
            OP_ENABLE: drive_on = r.enable_value;
            default: begin
                dt = longint'(32'(r.now_ms - tick_t));
                if (dt > timeout_ms) begin
                    dt = fallback_ms;
                    cur_speed = 0;
                    cur_rate = 0;
                end
                tick_t = r.now_ms;
                if (!(drive_on && dm_engaged)) begin
                    cur_speed = 0;
                    cur_rate = 0;
                end else begin
                    ss = (longint'(speed_slew_r) * dt) / 1000;
                    ts = (longint'(turn_slew_r) * dt) / 1000;
                    cur_speed = clip(cur_speed - ss, cur_speed + ss, want_speed);
                    cur_rate = clip(cur_rate - ts, cur_rate + ts, want_rate);
                    c.speed = 16'(cur_speed);
                    c.steer_mrad = 12'(steer_angle(cur_speed, cur_rate));
                    expected_commands.push_back(c);
                end
            end
        endcase
    endtask

    // ---------------- clock and limit ----------------
    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd.valid <= 0;
        end else begin
            if (cmd.valid && cmd.ready) predict_command(pending_requests.pop_front());
            // offer the head of the queue unless idling or paused
            if ((!cmd.valid || cmd.ready)) begin
                if (pending_requests.size() > (cmd.valid && cmd.ready ? 0 : 0) && !sender_pause
                    && $urandom_range(99) >= send_idle_pct) begin
                    cmd.valid <= 1;
                    cmd.opcode <= pending_requests[0].op;
                    cmd.now_ms <= pending_requests[0].now_ms;
                    cmd.start_button <= pending_requests[0].start_button;
                    cmd.deadman_button <= pending_requests[0].deadman_button;
                    cmd.target_speed <= pending_requests[0].target_speed;
                    cmd.curvature <= pending_requests[0].curvature;
                    cmd.enable_value <= pending_requests[0].enable_value;
                end else begin
                    cmd.valid <= 0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        t_command e;
        if (!i_rst_n) begin
            res.ready <= 0;
        end else begin
            if (res.valid && res.ready) begin
                if (expected_commands.size() == 0) begin
                    $error("result with none expected: speed %0d angle %0d",
                           res.speed, res.steer_mrad);
                    errors++;
                end else begin
                    e = expected_commands.pop_front();
                    if (res.speed !== e.speed) begin
                        $error("speed: expected %0d, got %0d", e.speed, res.speed);
                        errors++;
                    end
                    if (res.steer_mrad !== e.steer_mrad) begin
                        $error("steer_mrad: expected %0d, got %0d",
                               e.steer_mrad, res.steer_mrad);
                        errors++;
                    end
                end
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                res.ready <= 0;
            end else begin
                res.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // ---------------- stimulus ----------------
    logic [31:0] clock_ms;

    task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            CFG_WHEELBASE:  wheelbase = v[10:0];
            CFG_SPEED_SLEW: speed_slew_r = v[15:0];
            CFG_TURN_SLEW:  turn_slew_r = v[19:0];
            CFG_DEBOUNCE:   debounce_ms = v[15:0];
            CFG_HOLD:       hold_ms = v[15:0];
            CFG_TIMEOUT:    timeout_ms = v[15:0];
            default:        fallback_ms = v[15:0];
        endcase
    endtask

    task automatic add_request(input t_opcode op, input logic [31:0] t, input logic sb,
                               input logic db, input logic [15:0] spd,
                               input logic [15:0] crv, input logic en);
        t_request r;
        r.op = op; r.now_ms = t; r.start_button = sb; r.deadman_button = db;
        r.target_speed = spd; r.curvature = crv; r.enable_value = en;
        pending_requests.push_back(r);
    endtask

    // wait until everything sent is answered, then let a tick finish
    task automatic drain();
        while (pending_requests.size() != 0 || expected_commands.size() != 0
               || cmd.valid)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    // mostly well-formed drive sessions: engage deadman, setpoint, ticks
    task automatic random_session(input int n);
        for (int k = 0; k < n; k++) begin
            int pick;
            pick = $urandom_range(99);
            if (pick < 8) begin
                add_request(OP_JOYSTICK, clock_ms,
                            1'($urandom_range(1) & ($urandom_range(3) == 0)),
                            $urandom_range(9) != 0, 16'($urandom), 16'($urandom),
                            1'($urandom));
                clock_ms += $urandom_range(hold_ms + 300);
                add_request(OP_JOYSTICK, clock_ms, 1'b0, 1'b1, 16'($urandom), 16'($urandom),
                            1'($urandom));
            end else if (pick < 20) begin
                add_request(OP_SETPOINT, $urandom, 1'($urandom), 1'($urandom),
                            ($urandom_range(4) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(4000) - 2000),
                            16'($urandom), 1'($urandom));
            end else if (pick < 23) begin
                add_request(OP_ENABLE, $urandom, 1'($urandom), 1'($urandom), 16'($urandom),
                            16'($urandom), $urandom_range(7) != 0);
            end else if (pick < 25) begin
                add_request(t_opcode'(OP_TICK), $urandom, 1'($urandom), 1'($urandom),
                            16'($urandom), 16'($urandom), 1'($urandom));
            end else begin
                clock_ms += ($urandom_range(19) == 0) ? $urandom_range(5000)
                                                       : $urandom_range(120);
                add_request(OP_TICK, clock_ms, 1'($urandom), 1'($urandom), 16'($urandom),
                            16'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin
        errors = 0;
        hold_off_cycles = 0;
        sender_pause = 0;
        send_idle_pct = 17;
        recv_idle_pct = 53;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_index = CFG_WHEELBASE;
        i_cfg_data = '0;
        cmd.valid = 0;
        cmd.opcode = OP_TICK;
        cmd.now_ms = 0;
        cmd.start_button = 0;
        cmd.deadman_button = 0;
        cmd.target_speed = 0;
        cmd.curvature = 0;
        cmd.enable_value = 0;
        res.ready = 0;
        wheelbase = 200; speed_slew_r = 800; turn_slew_r = 10000;
        debounce_ms = 400; hold_ms = 1000; timeout_ms = 1000; fallback_ms = 50;
        cur_speed = 0; cur_rate = 0; want_speed = 0; want_rate = 0;
        drive_on = 1; dm_engaged = 0; dm_held = 0;
        dm_press_t = 0; toggle_t = 0; tick_t = 0;
        clock_ms = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: reset registers, deadman engage, field extremes
        add_request(OP_TICK, 10, 0, 0, 0, 0, 0);                 // not engaged
        add_request(OP_JOYSTICK, 20, 0, 1, 0, 0, 0);             // press begins
        add_request(OP_JOYSTICK, 1021, 0, 1, 0, 0, 0);           // hold elapsed
        add_request(OP_SETPOINT, 0, 0, 0, 16'sh7fff, 16'sh7fff, 0);
        add_request(OP_TICK, 1050, 0, 0, 0, 0, 0);
        add_request(OP_TICK, 1100, 1, 1, 16'hffff, 16'hffff, 1);
        add_request(OP_TICK, 5000, 0, 0, 0, 0, 0);               // timeout gap
        add_request(OP_SETPOINT, 0, 0, 0, 16'sh8000, 16'sh8000, 0);
        add_request(OP_TICK, 5050, 0, 0, 0, 0, 0);
        add_request(OP_SETPOINT, 0, 0, 0, 16'sh8000, 16'sh7fff, 0);
        add_request(OP_TICK, 5100, 0, 0, 0, 0, 0);
        add_request(OP_SETPOINT, 0, 0, 0, 0, 100, 0);            // zero speed target
        add_request(OP_TICK, 6000, 0, 0, 0, 0, 0);
        add_request(OP_JOYSTICK, 6010, 1, 1, 0, 0, 0);           // toggle off
        add_request(OP_JOYSTICK, 6020, 1, 1, 0, 0, 0);           // debounced
        add_request(OP_TICK, 6030, 0, 0, 0, 0, 0);               // disabled
        add_request(OP_ENABLE, 6040, 0, 0, 0, 0, 1);
        add_request(OP_TICK, 32'hffff_fff0, 0, 0, 0, 0, 0);     // wrap gap
        add_request(OP_TICK, 32'h0000_0010, 0, 0, 0, 0, 0);
        add_request(OP_JOYSTICK, 32'h20, 0, 0, 0, 0, 0);         // release
        add_request(OP_TICK, 32'h40, 0, 0, 0, 0, 0);
        add_request(OP_ENABLE, 0, 0, 0, 0, 0, 0);
        add_request(OP_TICK, 32'h60, 0, 0, 0, 0, 0);
        add_request(OP_ENABLE, 0, 0, 0, 0, 0, 1);
        clock_ms = 32'h100;
        random_session(500);
        // long receiver hold-off while the sender keeps offering
        hold_off_cycles = 3000;
        drain();

        // extremes of the registers, idling the other way round
        send_idle_pct = 53;
        recv_idle_pct = 17;
        write_reg(CFG_WHEELBASE, 20'd2000);
        write_reg(CFG_SPEED_SLEW, 20'd65535);
        write_reg(CFG_TURN_SLEW, 20'd1000000);
        write_reg(CFG_DEBOUNCE, 20'd0);
        write_reg(CFG_HOLD, 20'd0);
        write_reg(CFG_TIMEOUT, 20'd65535);
        write_reg(CFG_FALLBACK, 20'd65535);
        random_session(300);
        drain();
        write_reg(CFG_WHEELBASE, 20'd1);
        write_reg(CFG_SPEED_SLEW, 20'd0);
        write_reg(CFG_TURN_SLEW, 20'd0);
        write_reg(CFG_DEBOUNCE, 20'd65535);
        write_reg(CFG_HOLD, 20'd65535);
        write_reg(CFG_TIMEOUT, 20'd1);
        write_reg(CFG_FALLBACK, 20'd1);
        random_session(100);
        drain();

        // random registers, no idling; sender pauses until drained midway
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int ph = 0; ph < 3; ph++) begin
            write_reg(CFG_WHEELBASE, CFG_W'($urandom_range(2000, 1)));
            write_reg(CFG_SPEED_SLEW, CFG_W'($urandom_range(65535)));
            write_reg(CFG_TURN_SLEW, CFG_W'($urandom_range(1000000)));
            write_reg(CFG_DEBOUNCE, CFG_W'($urandom_range(1000)));
            write_reg(CFG_HOLD, CFG_W'($urandom_range(1500)));
            write_reg(CFG_TIMEOUT, CFG_W'($urandom_range(3000, 1)));
            write_reg(CFG_FALLBACK, CFG_W'($urandom_range(200, 1)));
            random_session(120);
            while (pending_requests.size() > 60) @(posedge i_clk);
            sender_pause = 1;
            while (expected_commands.size() != 0 || cmd.valid) @(posedge i_clk);
            sender_pause = 0;
            drain();
        end
        random_session(230);
        drain();

        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

/* files.f */
rtl/core/dcsl_pkg.sv
rtl/core/dcsl_cmd_if.sv
rtl/core/dcsl_res_if.sv
rtl/core/dcsl_div1000.sv
rtl/core/dcsl_cordic.sv
rtl/core/drive_command_slew_limiter.sv
tb/dcsl_tb_cmd_if.sv
tb/drive_command_slew_limiter_tb.sv
